FILE: hdl/tmfh_pkg.sv
package tmfh_pkg;

	localparam int MAP_SIDE  = 64;
	localparam int FRAC_BITS = 8;

	localparam int TILE_COUNT = MAP_SIDE * MAP_SIDE;
	localparam int ADDR_W     = $clog2(TILE_COUNT);
	localparam int COORD_W    = $clog2(MAP_SIDE + 1);

	localparam int IDX_W    = 12;
	localparam int KIND_W   = 4;
	localparam int LEVEL_W  = 16;
	localparam int RISE_W   = 8;
	localparam int POS_W    = 16;
	localparam int EXT_W    = 32;
	localparam int HEIGHT_W = 25;
	localparam int CALC_W   = LEVEL_W + FRAC_BITS + 2;
	localparam int PROD_W   = RISE_W + FRAC_BITS;

	localparam longint POS_LIM = longint'(MAP_SIDE) * (longint'(1) << FRAC_BITS);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [KIND_W-1:0] KIND_SOLID   = 4'd0;
	localparam logic [KIND_W-1:0] KIND_OPEN    = 4'd1;
	localparam logic [KIND_W-1:0] KIND_DIAG_SE = 4'd2;
	localparam logic [KIND_W-1:0] KIND_DIAG_SW = 4'd3;
	localparam logic [KIND_W-1:0] KIND_DIAG_NW = 4'd4;
	localparam logic [KIND_W-1:0] KIND_DIAG_NE = 4'd5;
	localparam logic [KIND_W-1:0] KIND_SLOPE_N = 4'd6;
	localparam logic [KIND_W-1:0] KIND_SLOPE_S = 4'd7;
	localparam logic [KIND_W-1:0] KIND_SLOPE_E = 4'd8;
	localparam logic [KIND_W-1:0] KIND_SLOPE_W = 4'd9;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_QUERY   = 2'd1,
		OP_OUTSIDE = 2'd2
	} op_t;

	typedef struct packed {
		logic                     command;
		logic [IDX_W-1:0]         tile_index;
		logic [KIND_W-1:0]        tile_kind;
		logic [LEVEL_W-1:0]       floor_level;
		logic [LEVEL_W-1:0]       ceiling_level;
		logic [RISE_W-1:0]        slope_rise;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
	} in_item_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
		logic                outside;
	} out_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [LEVEL_W-1:0] floor_level;
		logic [LEVEL_W-1:0] ceiling_level;
		logic [RISE_W-1:0]  slope_rise;
	} tile_t;

	localparam int TILE_W = $bits(tile_t);

	typedef struct packed {
		op_t                  op;
		logic [ADDR_W-1:0]    addr;
		tile_t                tile;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

endpackage

FILE: hdl/tmfh_ram.sv
module tmfh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

FILE: hdl/tmfh_front.sv
module tmfh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tmfh_pkg::in_item_t  item,
	output tmfh_pkg::q_head_t   head,
	input  logic                head_pop
);

	logic [tmfh_pkg::EXT_W-1:0]   ux;
	logic [tmfh_pkg::EXT_W-1:0]   uy;
	logic [tmfh_pkg::COORD_W-1:0] qx;
	logic [tmfh_pkg::COORD_W-1:0] qy;
	logic [tmfh_pkg::COORD_W-1:0] tx;
	logic [tmfh_pkg::COORD_W-1:0] ty;
	logic                         is_out;
	logic                         keep;
	logic                         wr_en;
	tmfh_pkg::q_entry_t           entry;

	tmfh_pkg::q_entry_t              mem_q [tmfh_pkg::Q_DEPTH];
	logic [tmfh_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [tmfh_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [tmfh_pkg::Q_CNT_W-1:0]    cnt_q;

	assign ux = {{(tmfh_pkg::EXT_W - tmfh_pkg::POS_W){1'b0}}, item.pos_x};
	assign uy = {{(tmfh_pkg::EXT_W - tmfh_pkg::POS_W){1'b0}}, item.pos_y};
	assign qx = tmfh_pkg::COORD_W'(ux >> tmfh_pkg::FRAC_BITS);
	assign qy = tmfh_pkg::COORD_W'(uy >> tmfh_pkg::FRAC_BITS);
	assign tx = (qx == tmfh_pkg::COORD_W'(tmfh_pkg::MAP_SIDE)) ? '0 : qx;
	assign ty = (qy == tmfh_pkg::COORD_W'(tmfh_pkg::MAP_SIDE)) ? '0 : qy;

	assign is_out = item.pos_x[tmfh_pkg::POS_W-1] || item.pos_y[tmfh_pkg::POS_W-1]
		|| (longint'(item.pos_x) > tmfh_pkg::POS_LIM)
		|| (longint'(item.pos_y) > tmfh_pkg::POS_LIM);

	always_comb begin
		entry.tile.kind          = item.tile_kind;
		entry.tile.floor_level   = item.floor_level;
		entry.tile.ceiling_level = item.ceiling_level;
		entry.tile.slope_rise    = item.slope_rise;
		entry.fx                 = ux[tmfh_pkg::FRAC_BITS-1:0];
		entry.fy                 = uy[tmfh_pkg::FRAC_BITS-1:0];
		keep                     = 1'b1;
		if (item.command == tmfh_pkg::CMD_WRITE) begin
			entry.op   = tmfh_pkg::OP_WRITE;
			entry.addr = tmfh_pkg::ADDR_W'(item.tile_index);
			keep       = longint'(item.tile_index) < longint'(tmfh_pkg::TILE_COUNT);
		end else if (is_out) begin
			entry.op   = tmfh_pkg::OP_OUTSIDE;
			entry.addr = '0;
		end else begin
			entry.op   = tmfh_pkg::OP_QUERY;
			entry.addr = tmfh_pkg::ADDR_W'(int'(ty) * tmfh_pkg::MAP_SIDE + int'(tx));
		end
	end

	assign full  = (cnt_q == tmfh_pkg::Q_CNT_W'(tmfh_pkg::Q_DEPTH));
	assign wr_en = push && !full && keep;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == tmfh_pkg::Q_PTR_W'(tmfh_pkg::Q_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (head_pop) begin
				rd_ptr_q <= (rd_ptr_q == tmfh_pkg::Q_PTR_W'(tmfh_pkg::Q_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !head_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && head_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

endmodule

FILE: hdl/tmfh_back.sv
module tmfh_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tmfh_pkg::q_head_t                  head,
	output logic                               head_pop,
	output logic                               ram_en,
	output logic                               ram_we,
	output logic [tmfh_pkg::ADDR_W-1:0]        ram_addr,
	output logic [tmfh_pkg::TILE_W-1:0]        ram_wdata,
	input  logic [tmfh_pkg::TILE_W-1:0]        ram_rdata,
	output logic                               empty,
	input  logic                               pop,
	output tmfh_pkg::out_item_t                result
);

	logic                           credit_ok;
	logic                           is_write;
	logic                           valid_s1;
	logic                           outside_s1;
	logic [tmfh_pkg::FRAC_BITS-1:0] fx_s1;
	logic [tmfh_pkg::FRAC_BITS-1:0] fy_s1;

	tmfh_pkg::tile_t                t;
	logic [tmfh_pkg::CALC_W-1:0]    fl;
	logic [tmfh_pkg::CALC_W-1:0]    ce;
	logic [tmfh_pkg::CALC_W-1:0]    top;
	logic [tmfh_pkg::CALC_W-1:0]    h;
	logic [tmfh_pkg::FRAC_BITS-1:0] sel_f;
	logic [tmfh_pkg::PROD_W-1:0]    prod;
	logic [tmfh_pkg::FRAC_BITS:0]   fsum;
	logic [tmfh_pkg::FRAC_BITS:0]   frac_one;
	tmfh_pkg::out_item_t            res;

	tmfh_pkg::out_item_t              out_mem_q [tmfh_pkg::OUT_DEPTH];
	logic [tmfh_pkg::OUT_PTR_W-1:0]   out_wr_q;
	logic [tmfh_pkg::OUT_PTR_W-1:0]   out_rd_q;
	logic [tmfh_pkg::OUT_CNT_W-1:0]   out_cnt_q;
	logic                             out_pop;

	assign is_write  = (head.entry.op == tmfh_pkg::OP_WRITE);
	assign credit_ok = ({1'b0, out_cnt_q} + {{tmfh_pkg::OUT_CNT_W{1'b0}}, valid_s1})
		< (tmfh_pkg::OUT_CNT_W + 1)'(tmfh_pkg::OUT_DEPTH);
	assign head_pop  = head.valid && (is_write || credit_ok);

	assign ram_en    = head_pop && (head.entry.op != tmfh_pkg::OP_OUTSIDE);
	assign ram_we    = is_write;
	assign ram_addr  = head.entry.addr;
	assign ram_wdata = head.entry.tile;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= head_pop && !is_write;
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			outside_s1 <= (head.entry.op == tmfh_pkg::OP_OUTSIDE);
			fx_s1      <= head.entry.fx;
			fy_s1      <= head.entry.fy;
		end
	end

	assign t        = ram_rdata;
	assign frac_one = (tmfh_pkg::FRAC_BITS + 1)'(1) << tmfh_pkg::FRAC_BITS;
	assign fsum     = {1'b0, fx_s1} + {1'b0, fy_s1};
	assign fl       = tmfh_pkg::CALC_W'(t.floor_level) << tmfh_pkg::FRAC_BITS;
	assign ce       = tmfh_pkg::CALC_W'(t.ceiling_level) << tmfh_pkg::FRAC_BITS;
	assign top      = (tmfh_pkg::CALC_W'(t.floor_level) + tmfh_pkg::CALC_W'(t.slope_rise))
		<< tmfh_pkg::FRAC_BITS;
	assign sel_f    = (t.kind == tmfh_pkg::KIND_SLOPE_E || t.kind == tmfh_pkg::KIND_SLOPE_W)
		? fx_s1 : fy_s1;
	assign prod     = tmfh_pkg::PROD_W'(t.slope_rise) * tmfh_pkg::PROD_W'(sel_f);

	always_comb begin
		unique case (t.kind) inside
			tmfh_pkg::KIND_SOLID:   h = ce;
			tmfh_pkg::KIND_DIAG_SE: h = (fx_s1 < fy_s1) ? ce : fl;
			tmfh_pkg::KIND_DIAG_SW: h = (fsum > frac_one) ? ce : fl;
			tmfh_pkg::KIND_DIAG_NW: h = (fx_s1 > fy_s1) ? ce : fl;
			tmfh_pkg::KIND_DIAG_NE: h = (fsum < frac_one) ? ce : fl;
			tmfh_pkg::KIND_SLOPE_N,
			tmfh_pkg::KIND_SLOPE_E: h = fl + tmfh_pkg::CALC_W'(prod);
			tmfh_pkg::KIND_SLOPE_S,
			tmfh_pkg::KIND_SLOPE_W: h = top - tmfh_pkg::CALC_W'(prod);
			default:                h = fl;
		endcase
		if (outside_s1) begin
			res.height  = '0;
			res.outside = 1'b1;
		end else begin
			res.height  = tmfh_pkg::HEIGHT_W'(h);
			res.outside = 1'b0;
		end
	end

	assign empty   = (out_cnt_q == '0);
	assign out_pop = pop && !empty;
	assign result  = out_mem_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_mem_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				out_wr_q <= (out_wr_q == tmfh_pkg::OUT_PTR_W'(tmfh_pkg::OUT_DEPTH - 1))
					? '0 : out_wr_q + 1'b1;
			end
			if (out_pop) begin
				out_rd_q <= (out_rd_q == tmfh_pkg::OUT_PTR_W'(tmfh_pkg::OUT_DEPTH - 1))
					? '0 : out_rd_q + 1'b1;
			end
			if (valid_s1 && !out_pop) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (!valid_s1 && out_pop) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> out_cnt_q != tmfh_pkg::OUT_CNT_W'(tmfh_pkg::OUT_DEPTH))
		else $error("result buffer overflow");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, out_cnt_q} + {{tmfh_pkg::OUT_CNT_W{1'b0}}, valid_s1})
		<= (tmfh_pkg::OUT_CNT_W + 1)'(tmfh_pkg::OUT_DEPTH))
		else $error("results in flight exceed buffer space");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop && is_write |=> !valid_s1)
		else $error("tile write produced a result");

	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop && !is_write |=> valid_s1)
		else $error("query lost between issue and result");
`endif

endmodule

FILE: hdl/tile_map_floor_height_core.sv
// Tile map floor height core.
// Input channel: a queue-style port. Drive item and raise push; the item is
// taken at a clock edge where push is high and full is low. command selects a
// tile write (no result) or a height query (exactly one result).
// Result channel: while empty is low, result holds the oldest answer; raise
// pop to take it at a clock edge.
// Path: front queue, tile memory read with stage-1 registers, result buffer.
// Throughput: one item per cycle while the result buffer has room, set by the
// single tile memory port, which serves one write or one read each cycle.
// A small front queue holds classified items; a four-entry result buffer
// holds answers. When the receiver stalls, the result buffer fills, the back
// end stops issuing queries, the front queue fills and full rises.
// Tile writes continue to drain while results are stalled only up to the
// first query waiting in the front queue.
// Reset clears both queues; tile memory contents stay undefined until each
// tile is written, and no clearing pass runs.
module tile_map_floor_height_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  tmfh_pkg::in_item_t   item,
	output logic                 empty,
	input  logic                 pop,
	output tmfh_pkg::out_item_t  result
);

	tmfh_pkg::q_head_t              head;
	logic                           head_pop;
	logic                           ram_en;
	logic                           ram_we;
	logic [tmfh_pkg::ADDR_W-1:0]    ram_addr;
	logic [tmfh_pkg::TILE_W-1:0]    ram_wdata;
	logic [tmfh_pkg::TILE_W-1:0]    ram_rdata;

	tmfh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.head     (head),
		.head_pop (head_pop)
	);

	tmfh_ram #(
		.WIDTH (tmfh_pkg::TILE_W),
		.DEPTH (tmfh_pkg::TILE_COUNT)
	) u_tile_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	tmfh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_pop  (head_pop),
		.ram_en    (ram_en),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
